// ===== sv/pcx_pkg.sv =====
// Shared types, codes and constants of the PCX run-length decoder.
package pcx_pkg;

    // Header length in bytes; the corner words sit at offsets 4 to 11.
    localparam int HEADER_BYTES = 128;
    localparam int HDR_OFF_W    = $clog2(HEADER_BYTES);

    // Header offsets that carry checks or corner bytes
    localparam logic [HDR_OFF_W-1:0] HDR_VERSION  = HDR_OFF_W'(1);
    localparam logic [HDR_OFF_W-1:0] HDR_ENCODING = HDR_OFF_W'(2);
    localparam logic [HDR_OFF_W-1:0] HDR_DEPTH    = HDR_OFF_W'(3);
    localparam logic [HDR_OFF_W-1:0] HDR_XMIN_LO  = HDR_OFF_W'(4);
    localparam logic [HDR_OFF_W-1:0] HDR_XMIN_HI  = HDR_OFF_W'(5);
    localparam logic [HDR_OFF_W-1:0] HDR_YMIN_LO  = HDR_OFF_W'(6);
    localparam logic [HDR_OFF_W-1:0] HDR_YMIN_HI  = HDR_OFF_W'(7);
    localparam logic [HDR_OFF_W-1:0] HDR_XMAX_LO  = HDR_OFF_W'(8);
    localparam logic [HDR_OFF_W-1:0] HDR_XMAX_HI  = HDR_OFF_W'(9);
    localparam logic [HDR_OFF_W-1:0] HDR_YMAX_LO  = HDR_OFF_W'(10);
    localparam logic [HDR_OFF_W-1:0] HDR_YMAX_HI  = HDR_OFF_W'(11);

    // Expected header values
    localparam logic [7:0] VERSION_VAL  = 8'd5;
    localparam logic [7:0] ENCODING_VAL = 8'd1;
    localparam logic [7:0] DEPTH_VAL    = 8'd8;

    // Top two bits of a data byte that mark a repeat count
    localparam logic [1:0] COUNT_MARK = 2'b11;

    // Result kinds
    localparam logic [1:0] KIND_RUN    = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_VERSION  = 2'd0;
    localparam logic [1:0] ERR_ENCODING = 2'd1;
    localparam logic [1:0] ERR_DEPTH    = 2'd2;
    localparam logic [1:0] ERR_SIZE     = 2'd3;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_DATA   = 4'b0010,
        PH_ERROR  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [HDR_OFF_W-1:0]   header_offset;
        logic [15:0]            corner_start_x;
        logic [15:0]            corner_start_y;
        logic [15:0]            corner_end_x;
        logic [15:0]            corner_end_y;
        logic [15:0]            row_width;
        logic [15:0]            rows_left;
        logic [15:0]            current_row;
        logic [15:0]            column;
        logic                   value_pending;
        logic [5:0]             pending_count;
    } dec_state_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  run_value;
        logic [15:0] run_length;
        logic [15:0] row_index;
        logic [15:0] start_column;
        logic        row_end;
        logic        image_end;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  error_code;
    } result_t;

    localparam dec_state_t STATE_RESET = '{
        phase:          PH_HEADER,
        header_offset:  '0,
        corner_start_x: 16'd0,
        corner_start_y: 16'd0,
        corner_end_x:   16'd0,
        corner_end_y:   16'd0,
        row_width:      16'd0,
        rows_left:      16'd0,
        current_row:    16'd0,
        column:         16'd0,
        value_pending:  1'b0,
        pending_count:  6'd0
    };

    localparam result_t RESULT_ZERO = '0;

endpackage

// ===== sv/pcx_step.sv =====
// Per-byte next-state and result logic of the PCX run-length decoder.
module pcx_step (
    input  pcx_pkg::dec_state_t cur,
    input  logic [7:0]          byte_in,
    input  logic                frame_start,
    output pcx_pkg::dec_state_t nxt,
    output logic                emit,
    output pcx_pkg::result_t    res
);
    import pcx_pkg::*;

    dec_state_t           s;
    logic [HDR_OFF_W:0]   off_inc;
    logic                 hdr_last;
    logic                 hdr_err;
    logic [1:0]           hdr_code;
    logic [15:0]          img_w;
    logic [15:0]          img_h;
    logic [5:0]           run_cnt;
    logic [15:0]          run_cnt_ext;
    logic [15:0]          left;
    logic [15:0]          run_len;
    logic                 rend;
    logic                 iend;

    always_comb
    begin
        // restart wipes everything before the byte is looked at
        s        = frame_start ? STATE_RESET : cur;
        nxt      = s;
        res      = RESULT_ZERO;
        emit     = 1'b0;
        hdr_err  = 1'b0;
        hdr_code = ERR_VERSION;

        off_inc  = {1'b0, s.header_offset} + (HDR_OFF_W + 1)'(1);
        hdr_last = (off_inc >= (HDR_OFF_W + 1)'(HEADER_BYTES));

        // run geometry: column is always below row_width in the data phase
        run_cnt     = s.value_pending ? s.pending_count : 6'd1;
        run_cnt_ext = {10'd0, run_cnt};
        left        = s.row_width - s.column;
        run_len     = ((run_cnt == 6'd0) || (run_cnt_ext > left)) ? left : run_cnt_ext;
        rend        = (run_len == left);
        iend        = rend && (s.rows_left == 16'd1);

        unique case (s.header_offset)
            HDR_VERSION:  if (byte_in != VERSION_VAL)
                          begin
                              hdr_err  = 1'b1;
                              hdr_code = ERR_VERSION;
                          end
            HDR_ENCODING: if (byte_in != ENCODING_VAL)
                          begin
                              hdr_err  = 1'b1;
                              hdr_code = ERR_ENCODING;
                          end
            HDR_DEPTH:    if (byte_in != DEPTH_VAL)
                          begin
                              hdr_err  = 1'b1;
                              hdr_code = ERR_DEPTH;
                          end
            HDR_XMIN_LO:  nxt.corner_start_x[7:0]  = byte_in;
            HDR_XMIN_HI:  nxt.corner_start_x[15:8] = byte_in;
            HDR_YMIN_LO:  nxt.corner_start_y[7:0]  = byte_in;
            HDR_YMIN_HI:  nxt.corner_start_y[15:8] = byte_in;
            HDR_XMAX_LO:  nxt.corner_end_x[7:0]    = byte_in;
            HDR_XMAX_HI:  nxt.corner_end_x[15:8]   = byte_in;
            HDR_YMAX_LO:  nxt.corner_end_y[7:0]    = byte_in;
            HDR_YMAX_HI:  nxt.corner_end_y[15:8]   = byte_in;
            default:      ;
        endcase

        img_w = nxt.corner_end_x - nxt.corner_start_x + 16'd1;
        img_h = nxt.corner_end_y - nxt.corner_start_y + 16'd1;

        unique case (s.phase)
            PH_HEADER:
            begin
                if (hdr_err)
                begin
                    emit            = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code  = hdr_code;
                    nxt.phase       = PH_ERROR;
                end
                else if (hdr_last)
                begin
                    emit = 1'b1;
                    if ((img_w == 16'd0) || (img_h == 16'd0))
                    begin
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_SIZE;
                        nxt.phase       = PH_ERROR;
                    end
                    else
                    begin
                        res.result_kind   = KIND_HEADER;
                        res.image_width   = img_w;
                        res.image_height  = img_h;
                        nxt.row_width     = img_w;
                        nxt.rows_left     = img_h;
                        nxt.current_row   = 16'd0;
                        nxt.column        = 16'd0;
                        nxt.value_pending = 1'b0;
                        nxt.pending_count = 6'd0;
                        nxt.phase         = PH_DATA;
                    end
                end
                else
                begin
                    nxt.header_offset = off_inc[HDR_OFF_W-1:0];
                end
            end
            PH_DATA:
            begin
                if (!s.value_pending && (byte_in[7:6] == COUNT_MARK))
                begin
                    // hold the count until the value byte arrives
                    nxt.pending_count = byte_in[5:0];
                    nxt.value_pending = 1'b1;
                end
                else
                begin
                    emit              = 1'b1;
                    res.result_kind   = KIND_RUN;
                    res.run_value     = byte_in;
                    res.run_length    = run_len;
                    res.row_index     = s.current_row;
                    res.start_column  = s.column;
                    res.row_end       = rend;
                    res.image_end     = iend;
                    nxt.value_pending = 1'b0;
                    if (rend)
                    begin
                        nxt.column      = 16'd0;
                        nxt.current_row = s.current_row + 16'd1;
                        nxt.rows_left   = s.rows_left - 16'd1;
                        if (s.rows_left == 16'd1)
                        begin
                            nxt.phase = PH_DONE;
                        end
                    end
                    else
                    begin
                        nxt.column = s.column + run_len;
                    end
                end
            end
            PH_ERROR, PH_DONE: ;
            default: ;
        endcase
    end

endmodule

// ===== sv/pcx_rle_decoder_core.sv =====
// Top level of the PCX 8-bit run-length decoder: request registers and result register.
//
// Feed the image file one byte per request; set frame_start on the first header byte
// to restart parsing at any time. The block checks version, encoding and bit depth
// (header bytes 1 to 3), reads the window corners from bytes 4 to 11 and, on the last
// header byte, returns either a header result carrying width and height or a size
// error. After that each data byte gives at most one run result (value, clipped
// length, row, start column, row-end and image-end flags); a count byte gives none.
// Header errors latch until the next restart, and bytes after the last row are
// dropped silently. Throughput is one byte per clock with no gaps while the result
// side does not stall: a request is taken into an input register, decoded by a single
// combinational step into the state and result registers, and the result is presented
// on the output from the result register. Back-pressure on the result side stalls the
// decode stage only when the result register is full and not being drained.
module pcx_rle_decoder_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        frame_start,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  run_value,
    output logic [15:0] run_length,
    output logic [15:0] row_index,
    output logic [15:0] start_column,
    output logic        row_end,
    output logic        image_end,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [1:0]  error_code
);
    import pcx_pkg::*;

    // input stage
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;

    // decoder state
    dec_state_t state_reg;
    dec_state_t state_next;

    // result stage
    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    logic       emit;

    logic       advance;

    // decode the held request when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    pcx_step u_step (
        .cur         (state_reg),
        .byte_in     (byte_reg),
        .frame_start (start_reg),
        .nxt         (state_next),
        .emit        (emit),
        .res         (res_next)
    );

    // control: input valid, result valid and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= byte_in;
            start_reg <= frame_start;
        end
        if (advance && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = res_reg.result_kind;
    assign run_value    = res_reg.run_value;
    assign run_length   = res_reg.run_length;
    assign row_index    = res_reg.row_index;
    assign start_column = res_reg.start_column;
    assign row_end      = res_reg.row_end;
    assign image_end    = res_reg.image_end;
    assign image_width  = res_reg.image_width;
    assign image_height = res_reg.image_height;
    assign error_code   = res_reg.error_code;

    // column never reaches the row width while runs are being decoded
    a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DATA) |-> (state_reg.column < state_reg.row_width))
        else $error("column ran past the row width");

    // a run that ends the image also ends its row
    a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.result_kind == KIND_RUN) && res_reg.image_end)
            |-> res_reg.row_end)
        else $error("image end without row end");

    // the decode stage never overwrites a result that has not been taken
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("pending result was lost or changed");

endmodule
